FILE: hdl/crt_pkg.sv
// Shared constants and types for the credential record table.
package crt_pkg;

    localparam int ENTRIES   = 16;
    localparam int REC_BYTES = 6;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int SCAN_W    = (IDX_W > 4) ? IDX_W : 4;

    localparam logic [7:0] EMPTY_MARK = 8'h2D;

    localparam logic [2:0] CMD_FIND      = 3'd0;
    localparam logic [2:0] CMD_CHECK     = 3'd1;
    localparam logic [2:0] CMD_INSERT    = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;
    localparam logic [2:0] CMD_WRITE     = 3'd6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // byte p of a record sits at bits [8p+7:8p]
    typedef logic [8*REC_BYTES-1:0] t_rec;

    localparam t_rec EMPTY_REC = {REC_BYTES{EMPTY_MARK}};

    typedef struct packed {
        logic shift;
        logic busy;
    } t_chain_ctl;

endpackage

FILE: hdl/crt_cell.sv
// One record cell of the rotating record chain.
module crt_cell (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_shift,
    input  crt_pkg::t_rec i_rec,
    output crt_pkg::t_rec o_rec
);
    import crt_pkg::*;

    t_rec r_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= EMPTY_REC;
        end else if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

FILE: hdl/crt_ctrl.sv
// Head-of-chain control: command capture, per-record match and update, result register.
module crt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_command,
    input  logic [7:0]          i_id_byte,
    input  logic [7:0]          i_spare_byte,
    input  logic [7:0]          i_pass_digit0,
    input  logic [7:0]          i_pass_digit1,
    input  logic [7:0]          i_pass_digit2,
    input  logic [7:0]          i_pass_digit3,
    input  logic [3:0]          i_slot,
    input  logic [2:0]          i_byte_pos,
    input  logic [7:0]          i_byte_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [3:0]          o_found_slot,
    output logic [7:0]          o_read_value,
    input  crt_pkg::t_rec       i_head,
    output crt_pkg::t_rec       o_tail,
    output crt_pkg::t_chain_ctl o_ctl
);
    import crt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [SCAN_W:0]  ENT_V    = (SCAN_W + 1)'(ENTRIES);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx;
    logic             r_found;
    logic [IDX_W-1:0] r_hit;
    logic [7:0]       r_rd;

    logic [2:0]  r_cmd;
    logic [7:0]  r_id, r_spare, r_val;
    logic [31:0] r_pw;
    logic [3:0]  r_slot;
    logic [2:0]  r_pos;

    logic       r_ovalid;
    logic [1:0] r_status;
    logic [3:0] r_fslot;
    logic [7:0] r_oread;

    logic             w_accept;
    logic             w_slot_ok, w_pos_ok, w_at_slot, w_hit, w_first, w_load;
    logic [7:0]       w_byte;
    t_rec             w_wr_rec;
    logic [SCAN_W-1:0] w_hit_ext;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_slot_ok = {1'b0, SCAN_W'(r_slot)} < ENT_V;
    assign w_pos_ok  = r_pos < 3'(REC_BYTES);
    assign w_at_slot = w_slot_ok && (SCAN_W'(r_idx) == SCAN_W'(r_slot));

    always_comb begin
        case (r_pos)
            3'd0:    w_byte = i_head[7:0];
            3'd1:    w_byte = i_head[15:8];
            3'd2:    w_byte = i_head[23:16];
            3'd3:    w_byte = i_head[31:24];
            3'd4:    w_byte = i_head[39:32];
            3'd5:    w_byte = i_head[47:40];
            default: w_byte = 8'd0;
        endcase
    end

    always_comb begin
        w_wr_rec = i_head;
        case (r_pos)
            3'd0:    w_wr_rec[7:0]   = r_val;
            3'd1:    w_wr_rec[15:8]  = r_val;
            3'd2:    w_wr_rec[23:16] = r_val;
            3'd3:    w_wr_rec[31:24] = r_val;
            3'd4:    w_wr_rec[39:32] = r_val;
            3'd5:    w_wr_rec[47:40] = r_val;
            default: w_wr_rec = i_head;
        endcase
    end

    always_comb begin
        case (r_cmd)
            CMD_FIND:   w_hit = i_head[7:0] == r_id;
            CMD_CHECK:  w_hit = i_head[47:16] == r_pw;
            CMD_INSERT: w_hit = i_head[7:0] == EMPTY_MARK;
            CMD_CLEAR:  w_hit = w_at_slot;
            CMD_READ:   w_hit = w_at_slot && w_pos_ok;
            CMD_WRITE:  w_hit = w_at_slot && w_pos_ok;
            default:    w_hit = 1'b0;
        endcase
    end

    assign w_first = w_hit && !r_found;

    // record handed back to the tail of the chain
    always_comb begin
        o_tail = i_head;
        if (r_cmd == CMD_CLEAR_ALL) begin
            o_tail = EMPTY_REC;
        end else if (w_first) begin
            case (r_cmd)
                CMD_INSERT: o_tail = {r_pw, r_spare, r_id};
                CMD_CLEAR:  o_tail = EMPTY_REC;
                CMD_WRITE:  o_tail = w_wr_rec;
                default:    o_tail = i_head;
            endcase
        end
    end

    assign w_load = (r_state == S_FINISH) && (!r_ovalid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (r_idx == LAST_IDX) n_state = S_FINISH;
            S_FINISH: if (w_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_idx <= r_idx + 1'b1;
                if (w_hit) r_found <= 1'b1;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= i_command;
            r_id    <= i_id_byte;
            r_spare <= i_spare_byte;
            r_pw    <= {i_pass_digit3, i_pass_digit2, i_pass_digit1, i_pass_digit0};
            r_slot  <= i_slot;
            r_pos   <= i_byte_pos;
            r_val   <= i_byte_value;
        end
        if (r_state == S_SCAN && w_first) begin
            r_hit <= r_idx;
            r_rd  <= w_byte;
        end
    end

    assign w_hit_ext = SCAN_W'(r_hit);

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_cmd == CMD_CLEAR_ALL) begin
                r_status <= ST_OK;
                r_fslot  <= 4'd0;
                r_oread  <= 8'd0;
            end else if (r_found) begin
                r_status <= ST_OK;
                r_fslot  <= w_hit_ext[3:0];
                r_oread  <= (r_cmd == CMD_READ) ? r_rd : 8'd0;
            end else begin
                r_status <= (r_cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
                r_fslot  <= 4'd0;
                r_oread  <= 8'd0;
            end
        end
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_ovalid;
    assign o_status     = r_status;
    assign o_found_slot = r_fslot;
    assign o_read_value = r_oread;
    assign o_ctl.shift  = r_state == S_SCAN;
    assign o_ctl.busy   = r_state != S_IDLE;

endmodule

FILE: hdl/credential_record_table.sv
// Top level of the credential record table: a rotating chain of record cells and its head control.
//
// Usage: one command item enters on i_in_valid/o_in_ready (fields i_command .. i_byte_value)
// and gives exactly one result item on o_out_valid/i_out_ready (o_status, o_found_slot,
// o_read_value). The table holds ENTRIES six-byte records, one per cell. For every command
// the whole chain rotates once, one record per cycle past the head, where it is compared
// and, for insert, clear, clear all or write, rewritten on its way back to the tail.
// Searches report the lowest matching slot.
// The block takes one item at a time and accepts the next only after the full rotation of
// the cell chain for the last one.
// A finished result sits in an output register; the next item is accepted while it
// waits. If the receiver still stalls when the following result is ready, the block holds
// that result at the head and keeps o_in_ready low until the register frees up.
// Reset (synchronous, active low) empties every record to the 0x2D mark at once and leaves
// both channels idle; no clearing pass is needed.
module credential_record_table (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_id_byte,
    input  logic [7:0] i_spare_byte,
    input  logic [7:0] i_pass_digit0,
    input  logic [7:0] i_pass_digit1,
    input  logic [7:0] i_pass_digit2,
    input  logic [7:0] i_pass_digit3,
    input  logic [3:0] i_slot,
    input  logic [2:0] i_byte_pos,
    input  logic [7:0] i_byte_value,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_status,
    output logic [3:0] o_found_slot,
    output logic [7:0] o_read_value
);
    import crt_pkg::*;

    t_rec       w_rec [ENTRIES];
    t_rec       w_tail;
    t_chain_ctl w_ctl;

    crt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_id_byte     (i_id_byte),
        .i_spare_byte  (i_spare_byte),
        .i_pass_digit0 (i_pass_digit0),
        .i_pass_digit1 (i_pass_digit1),
        .i_pass_digit2 (i_pass_digit2),
        .i_pass_digit3 (i_pass_digit3),
        .i_slot        (i_slot),
        .i_byte_pos    (i_byte_pos),
        .i_byte_value  (i_byte_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_slot  (o_found_slot),
        .o_read_value  (o_read_value),
        .i_head        (w_rec[0]),
        .o_tail        (w_tail),
        .o_ctl         (w_ctl)
    );

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        if (g == ENTRIES - 1) begin : g_tail
            crt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ctl.shift),
                .i_rec   (w_tail),
                .o_rec   (w_rec[g])
            );
        end else begin : g_mid
            crt_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_ctl.shift),
                .i_rec   (w_rec[g+1]),
                .o_rec   (w_rec[g])
            );
        end
    end

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> w_ctl.shift)
        else $error("accepted item did not start a rotation");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.busy |-> !o_in_ready)
        else $error("input ready while a command is in progress");

    a_miss_zero_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_found_slot == 4'd0 && o_read_value == 8'd0)
        else $error("nonzero slot or data on a failed command");

    a_full_only_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) && o_status == ST_FULL |-> w_tail == w_rec[0])
        else $error("table-full result while the head record was being changed");
`endif

endmodule
